>>> hdl/mcpd_pkg.sv
// shared types and constants for the motor command pwm driver
package mcpd_pkg;

  localparam int DUTY_W  = 8;
  localparam int SPEED_W = 9;
  localparam int SUM_W   = SPEED_W + 1;

  localparam int PWM_PERIOD_DEF = 100;

  // item kinds
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // ascii command codes
  localparam logic [7:0] CMD_FWD      = 8'h32;  // '2'
  localparam logic [7:0] CMD_VEER_B   = 8'h33;  // '3'
  localparam logic [7:0] CMD_VEER_A   = 8'h34;  // '4'
  localparam logic [7:0] CMD_STOP     = 8'h35;  // '5'
  localparam logic [7:0] CMD_REV      = 8'h36;  // '6'
  localparam logic [7:0] CMD_SPIN_R   = 8'h37;  // '7'
  localparam logic [7:0] CMD_SPIN_L   = 8'h38;  // '8'
  localparam logic [7:0] CMD_FASTER   = 8'h39;  // '9'
  localparam logic [7:0] CMD_SLOWER   = 8'h64;  // 'd'
  localparam logic [7:0] CMD_OFF_CLR  = 8'h66;  // 'f'

  localparam logic [DUTY_W-1:0] BASE_FWD  = 8'd70;
  localparam logic [DUTY_W-1:0] BASE_REV  = 8'd50;
  localparam logic [DUTY_W-1:0] DUTY_SPIN = 8'd100;
  localparam logic [DUTY_W-1:0] DUTY_VEER = 8'd30;
  localparam logic [DUTY_W-1:0] DUTY_SLOW = 8'd10;

  localparam logic signed [SUM_W-1:0] OFFSET_STEP = 10'sd10;
  localparam logic signed [SUM_W-1:0] OFFSET_MAX  = 10'sd180;
  localparam logic signed [SUM_W-1:0] OFFSET_MIN  = -10'sd50;

  // direction bit order
  typedef struct packed {
    logic b_rev;
    logic b_fwd;
    logic a_rev;
    logic a_fwd;
  } dir_t;

  localparam dir_t DIR_STOP  = '{b_rev: 1'b0, b_fwd: 1'b0, a_rev: 1'b0, a_fwd: 1'b0};
  localparam dir_t DIR_FWD   = '{b_rev: 1'b0, b_fwd: 1'b1, a_rev: 1'b0, a_fwd: 1'b1};
  localparam dir_t DIR_REV   = '{b_rev: 1'b1, b_fwd: 1'b0, a_rev: 1'b1, a_fwd: 1'b0};
  localparam dir_t DIR_SPINR = '{b_rev: 1'b1, b_fwd: 1'b0, a_rev: 1'b0, a_fwd: 1'b1};
  localparam dir_t DIR_SPINL = '{b_rev: 1'b0, b_fwd: 1'b1, a_rev: 1'b1, a_fwd: 1'b0};

  // control and status between top level and a pwm channel
  typedef struct packed {
    logic              advance;
    logic [DUTY_W-1:0] duty;
  } pwm_ctrl_t;

  typedef struct packed {
    logic level;
    logic level_next;
  } pwm_stat_t;

endpackage

>>> hdl/mcpd_if.sv
// valid/ready channels for command items and pin level items
interface mcpd_cmd_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] command_byte;

  modport source (output valid, output operation, output command_byte, input ready);
  modport sink   (input valid, input operation, input command_byte, output ready);
endinterface

interface mcpd_pin_if;
  logic valid;
  logic ready;
  logic chan_a_forward;
  logic chan_a_reverse;
  logic chan_b_forward;
  logic chan_b_reverse;
  logic enable_a;
  logic enable_b;

  modport source (output valid, output chan_a_forward, output chan_a_reverse,
                  output chan_b_forward, output chan_b_reverse,
                  output enable_a, output enable_b, input ready);
  modport sink   (input valid, input chan_a_forward, input chan_a_reverse,
                  input chan_b_forward, input chan_b_reverse,
                  input enable_a, input enable_b, output ready);
endinterface

>>> hdl/mcpd_pwm_chan.sv
// one software-style pwm channel: phase counter and enable level
module mcpd_pwm_chan #(
  parameter int PWM_PERIOD = mcpd_pkg::PWM_PERIOD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mcpd_pkg::pwm_ctrl_t ctrl,
  output mcpd_pkg::pwm_stat_t stat
);

  localparam logic [mcpd_pkg::DUTY_W-1:0] PERIOD_W = mcpd_pkg::DUTY_W'(PWM_PERIOD);

  logic [mcpd_pkg::DUTY_W-1:0] phase;
  logic [mcpd_pkg::DUTY_W-1:0] phase_next;
  logic [mcpd_pkg::DUTY_W-1:0] phase_inc;
  logic                        level;
  logic                        level_next;

  always_comb begin
    phase_inc  = phase + 1'b1;
    phase_next = phase;
    level_next = level;
    if (ctrl.advance) begin
      phase_next = phase_inc;
      level_next = 1'b0;
      if (phase_inc < ctrl.duty) begin
        level_next = 1'b1;
      end else if (phase_inc >= PERIOD_W) begin
        phase_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      level <= 1'b0;
    end else begin
      phase <= phase_next;
      level <= level_next;
    end
  end

  assign stat.level      = level;
  assign stat.level_next = level_next;

endmodule

>>> hdl/motor_command_pwm_driver.sv
// top level: command decode, speed offset, duties and pin level output register
// Two-channel motor drive controller.
// cmd channel: each item is either a command byte (operation 0) or one pwm
// timer tick (operation 1). A command byte stops both motors, then selects a
// drive mode or changes the speed offset. A tick advances both phase counters
// and updates the two pwm enable levels.
// pins channel: exactly one item per accepted cmd item, in order, carrying
// the direction levels and enable levels as they stand after that item.
// The pin item is registered and appears in the cycle after its cmd item is accepted.
// Throughput: one item per cycle when pins does not stall; the update is a
// single pass of decode and compare logic into the state and output register.
// Reset clears the offset, duties, direction bits, counters and enable
// levels, and empties the output register.
// When the pins receiver stalls, the output register holds its item and cmd
// ready drops until that item is taken; with an empty or draining output
// register a new cmd item is taken every cycle.
module motor_command_pwm_driver #(
  parameter int PWM_PERIOD = mcpd_pkg::PWM_PERIOD_DEF
) (
  input logic        clk,
  input logic        rst,
  mcpd_cmd_if.sink   cmd,
  mcpd_pin_if.source pins
);

  logic signed [mcpd_pkg::SPEED_W-1:0] speed_offset;
  logic signed [mcpd_pkg::SPEED_W-1:0] speed_offset_next;
  logic [mcpd_pkg::DUTY_W-1:0]         duty_a;
  logic [mcpd_pkg::DUTY_W-1:0]         duty_a_next;
  logic [mcpd_pkg::DUTY_W-1:0]         duty_b;
  logic [mcpd_pkg::DUTY_W-1:0]         duty_b_next;
  mcpd_pkg::dir_t                      dir;
  mcpd_pkg::dir_t                      dir_next;

  logic signed [mcpd_pkg::SUM_W-1:0]   off_ext;
  logic signed [mcpd_pkg::SUM_W-1:0]   off_up;
  logic signed [mcpd_pkg::SUM_W-1:0]   off_down;
  logic [mcpd_pkg::DUTY_W-1:0]         duty_fwd;
  logic [mcpd_pkg::DUTY_W-1:0]         duty_rev;

  logic                                fire;
  logic                                is_cmd;
  logic                                out_valid;

  mcpd_pkg::pwm_ctrl_t                 ctrl_a;
  mcpd_pkg::pwm_ctrl_t                 ctrl_b;
  mcpd_pkg::pwm_stat_t                 stat_a;
  mcpd_pkg::pwm_stat_t                 stat_b;

  function automatic logic [mcpd_pkg::DUTY_W-1:0] with_offset(
    input logic [mcpd_pkg::DUTY_W-1:0]       base,
    input logic signed [mcpd_pkg::SUM_W-1:0] off
  );
    logic signed [mcpd_pkg::SUM_W-1:0] sum;
    sum = $signed({2'b00, base}) + off;
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed(mcpd_pkg::SUM_W'(255))) begin
      return '1;
    end
    return sum[mcpd_pkg::DUTY_W-1:0];
  endfunction

  assign cmd.ready = !out_valid || pins.ready;
  assign fire      = cmd.valid && cmd.ready;
  assign is_cmd    = (cmd.operation == mcpd_pkg::OP_CMD);

  assign off_ext  = {speed_offset[mcpd_pkg::SPEED_W-1], speed_offset};
  assign off_up   = off_ext + mcpd_pkg::OFFSET_STEP;
  assign off_down = off_ext - mcpd_pkg::OFFSET_STEP;
  assign duty_fwd = with_offset(mcpd_pkg::BASE_FWD, off_ext);
  assign duty_rev = with_offset(mcpd_pkg::BASE_REV, off_ext);

  always_comb begin
    speed_offset_next = speed_offset;
    duty_a_next       = duty_a;
    duty_b_next       = duty_b;
    dir_next          = dir;
    if (fire && is_cmd) begin
      // every command stops first
      dir_next    = mcpd_pkg::DIR_STOP;
      duty_a_next = '0;
      duty_b_next = '0;
      case (cmd.command_byte)
        mcpd_pkg::CMD_FWD: begin
          dir_next    = mcpd_pkg::DIR_FWD;
          duty_a_next = duty_fwd;
          duty_b_next = duty_fwd;
        end
        mcpd_pkg::CMD_VEER_B: begin
          dir_next    = mcpd_pkg::DIR_FWD;
          duty_a_next = duty_fwd;
          duty_b_next = mcpd_pkg::DUTY_VEER;
        end
        mcpd_pkg::CMD_VEER_A: begin
          dir_next    = mcpd_pkg::DIR_FWD;
          duty_a_next = mcpd_pkg::DUTY_SLOW;
          duty_b_next = duty_fwd;
        end
        mcpd_pkg::CMD_STOP: begin
          dir_next = mcpd_pkg::DIR_STOP;
        end
        mcpd_pkg::CMD_REV: begin
          dir_next    = mcpd_pkg::DIR_REV;
          duty_a_next = duty_rev;
          duty_b_next = duty_rev;
        end
        mcpd_pkg::CMD_SPIN_R: begin
          dir_next    = mcpd_pkg::DIR_SPINR;
          duty_a_next = mcpd_pkg::DUTY_SPIN;
          duty_b_next = mcpd_pkg::DUTY_SPIN;
        end
        mcpd_pkg::CMD_SPIN_L: begin
          dir_next    = mcpd_pkg::DIR_SPINL;
          duty_a_next = mcpd_pkg::DUTY_SPIN;
          duty_b_next = mcpd_pkg::DUTY_SPIN;
        end
        mcpd_pkg::CMD_FASTER: begin
          if (off_up > mcpd_pkg::OFFSET_MAX) begin
            speed_offset_next = mcpd_pkg::OFFSET_MAX[mcpd_pkg::SPEED_W-1:0];
          end else begin
            speed_offset_next = off_up[mcpd_pkg::SPEED_W-1:0];
          end
        end
        mcpd_pkg::CMD_SLOWER: begin
          if (off_down < mcpd_pkg::OFFSET_MIN) begin
            speed_offset_next = mcpd_pkg::OFFSET_MIN[mcpd_pkg::SPEED_W-1:0];
          end else begin
            speed_offset_next = off_down[mcpd_pkg::SPEED_W-1:0];
          end
        end
        mcpd_pkg::CMD_OFF_CLR: begin
          speed_offset_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_offset <= '0;
      duty_a       <= '0;
      duty_b       <= '0;
      dir          <= mcpd_pkg::DIR_STOP;
    end else begin
      speed_offset <= speed_offset_next;
      duty_a       <= duty_a_next;
      duty_b       <= duty_b_next;
      dir          <= dir_next;
    end
  end

  // ticks see the duties as they stand before this item
  assign ctrl_a.advance = fire && !is_cmd;
  assign ctrl_a.duty    = duty_a;
  assign ctrl_b.advance = fire && !is_cmd;
  assign ctrl_b.duty    = duty_b;

  mcpd_pwm_chan #(.PWM_PERIOD(PWM_PERIOD)) u_chan_a (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl_a),
    .stat (stat_a)
  );

  mcpd_pwm_chan #(.PWM_PERIOD(PWM_PERIOD)) u_chan_b (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl_b),
    .stat (stat_b)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (pins.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pins.chan_a_forward <= dir_next.a_fwd;
      pins.chan_a_reverse <= dir_next.a_rev;
      pins.chan_b_forward <= dir_next.b_fwd;
      pins.chan_b_reverse <= dir_next.b_rev;
      pins.enable_a       <= stat_a.level_next;
      pins.enable_b       <= stat_b.level_next;
    end
  end

  assign pins.valid = out_valid;

`ifndef SYNTHESIS
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    ($signed({speed_offset[mcpd_pkg::SPEED_W-1], speed_offset}) <= mcpd_pkg::OFFSET_MAX) &&
    ($signed({speed_offset[mcpd_pkg::SPEED_W-1], speed_offset}) >= mcpd_pkg::OFFSET_MIN))
    else $error("speed offset out of range");

  a_no_shoot_through: assert property (@(posedge clk) disable iff (rst)
    !(dir.a_fwd && dir.a_rev) && !(dir.b_fwd && dir.b_rev))
    else $error("channel driven both ways");

  a_cmd_keeps_levels: assert property (@(posedge clk) disable iff (rst)
    (fire && is_cmd) |=> (stat_a.level == $past(stat_a.level)) &&
                         (stat_b.level == $past(stat_b.level)))
    else $error("command item changed enable levels");

  a_tick_keeps_dir: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_cmd) |=> (dir == $past(dir)) && (duty_a == $past(duty_a)) &&
                          (duty_b == $past(duty_b)))
    else $error("tick item changed drive mode");
`endif

endmodule
